/* sv/mmis_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mmis_pkg
// Shared types, constants and helpers of the masked index stepper.
// ----------------------------------------------------------------------------
package mmis_pkg;

    localparam int MAX_DIMS   = 4;
    localparam int DIGIT_BITS = 16;
    localparam int LANES      = 4;
    localparam int EXT_BITS   = 17;
    localparam int DIMS_BITS  = 3;
    localparam int MASK_BITS  = 4;
    localparam int ADDR_BITS  = 5;
    localparam int DATA_BITS  = 32;
    localparam int DIM_LIMIT  = (MAX_DIMS < LANES) ? MAX_DIMS : LANES;

    typedef logic [DIGIT_BITS-1:0] t_digit;
    typedef logic [EXT_BITS-1:0]   t_extent;

    typedef enum logic [1:0] {
        FUNC_INC   = 2'd0,
        FUNC_DEC   = 2'd1,
        FUNC_ZERO  = 2'd2,
        FUNC_QUERY = 2'd3
    } t_func;

    typedef enum logic [2:0] {
        REG_DIMS   = 3'd0,
        REG_CLOSED = 3'd1,
        REG_EXT0   = 3'd2,
        REG_EXT1   = 3'd3,
        REG_EXT2   = 3'd4,
        REG_EXT3   = 3'd5
    } t_reg_idx;

    // Per-lane findings handed to the merging stage.
    typedef struct packed {
        logic   used;
        logic   match;
        logic   over;
        logic   at_max;
        logic   is_zero;
        logic   same;
        t_digit digit;
        t_digit inc;
        t_digit dec;
        t_digit emax;
    } t_lane_info;

    typedef struct packed {
        t_digit [LANES-1:0] digits;
        logic               step_error;
        logic               in_range;
        logic               at_last;
        logic               masked_equal;
    } t_result;

    // Largest digit a dimension allows: extent 0 acts as 1, and an extent
    // beyond the digit range saturates.
    function automatic t_digit eff_max(input t_extent ext);
        logic [63:0] wide;
        wide = 64'(ext);
        if (wide == 64'd0) begin
            return '0;
        end else if (wide > (64'd1 << DIGIT_BITS)) begin
            return '1;
        end else begin
            return t_digit'(wide - 64'd1);
        end
    endfunction

    // Number of dimensions in use after clipping to the legal range.
    function automatic logic [DIMS_BITS-1:0] used_dims(input logic [DIMS_BITS-1:0] dims);
        if (dims == '0) begin
            return DIMS_BITS'(1);
        end else if (32'(dims) > DIM_LIMIT) begin
            return DIMS_BITS'(DIM_LIMIT);
        end else begin
            return dims;
        end
    endfunction

endpackage
`default_nettype wire

/* sv/mmis_lane.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mmis_lane
// Examines one digit: class match, range, wrap points and step candidates.
// ----------------------------------------------------------------------------
module mmis_lane (
    input  wire logic                i_used,
    input  wire logic                i_closed,
    input  wire logic                i_flag_sel,
    input  wire mmis_pkg::t_digit    i_coord,
    input  wire mmis_pkg::t_digit    i_other,
    input  wire mmis_pkg::t_extent   i_extent,
    output mmis_pkg::t_lane_info     o_info
);

    mmis_pkg::t_digit emax;

    assign emax = mmis_pkg::eff_max(i_extent);

    always_comb begin
        o_info.used    = i_used;
        o_info.match   = i_used && (i_closed == i_flag_sel);
        o_info.over    = i_coord > emax;
        o_info.at_max  = i_coord == emax;
        o_info.is_zero = i_coord == '0;
        o_info.same    = i_coord == i_other;
        o_info.digit   = i_coord;
        o_info.inc     = i_coord + mmis_pkg::t_digit'(1);
        o_info.dec     = i_coord - mmis_pkg::t_digit'(1);
        o_info.emax    = emax;
    end

endmodule
`default_nettype wire

/* sv/mmis_merge.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mmis_merge
// Runs the carry or borrow across the lanes, fastest digit first, and
// folds the per-lane checks into the result word.
// ----------------------------------------------------------------------------
module mmis_merge (
    input  wire mmis_pkg::t_func                           i_func,
    input  wire mmis_pkg::t_lane_info [mmis_pkg::LANES-1:0] i_lanes,
    output mmis_pkg::t_result                              o_result
);

    logic carry;
    logic hit;

    always_comb begin
        carry                 = 1'b1;
        hit                   = 1'b0;
        o_result.in_range     = 1'b1;
        o_result.at_last      = 1'b1;
        o_result.masked_equal = 1'b1;
        for (int k = mmis_pkg::LANES - 1; k >= 0; k--) begin
            o_result.digits[k] = i_lanes[k].digit;
            if (i_lanes[k].used && i_lanes[k].over) begin
                o_result.in_range = 1'b0;
            end
            if (i_lanes[k].match && !i_lanes[k].at_max) begin
                o_result.at_last = 1'b0;
            end
            if (i_lanes[k].match && !i_lanes[k].same) begin
                o_result.masked_equal = 1'b0;
            end
            unique case (i_func)
                mmis_pkg::FUNC_INC: begin
                    if (carry && i_lanes[k].match) begin
                        if (i_lanes[k].over) begin
                            hit   = 1'b1;
                            carry = 1'b0;
                        end else if (i_lanes[k].at_max) begin
                            o_result.digits[k] = '0;
                        end else begin
                            o_result.digits[k] = i_lanes[k].inc;
                            carry              = 1'b0;
                        end
                    end
                end
                mmis_pkg::FUNC_DEC: begin
                    if (carry && i_lanes[k].match) begin
                        if (i_lanes[k].over) begin
                            hit   = 1'b1;
                            carry = 1'b0;
                        end else if (i_lanes[k].is_zero) begin
                            o_result.digits[k] = i_lanes[k].emax;
                        end else begin
                            o_result.digits[k] = i_lanes[k].dec;
                            carry              = 1'b0;
                        end
                    end
                end
                mmis_pkg::FUNC_ZERO: begin
                    if (i_lanes[k].match) begin
                        o_result.digits[k] = '0;
                    end
                end
                mmis_pkg::FUNC_QUERY: begin
                end
            endcase
        end
        // A carry that leaves the slowest digit means a full wrap or no
        // matching digit at all.
        o_result.step_error = ((i_func == mmis_pkg::FUNC_INC) || (i_func == mmis_pkg::FUNC_DEC))
                              && (hit || carry);
    end

endmodule
`default_nettype wire

/* sv/masked_multidim_index_stepper.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// masked_multidim_index_stepper
// Steps a masked four-digit mixed-radix index and reports range, last
// position and masked equality for every word.
// ----------------------------------------------------------------------------
//  Channel   Handshake                  Payload
//  input     i_valid / o_stall          i_func, i_flag_sel, i_coord_*, i_other_*
//  output    o_valid / i_stall          o_new_*, o_step_error, o_in_range,
//                                       o_at_last, o_masked_equal
//  config    APB psel/penable/pwrite    paddr, pwdata, prdata, pready
//
// One word is accepted per cycle while o_stall is low; each result is
// registered in the lane stage and then in the carry-merge stage.
// Reset is synchronous, sets the registers to defaults and clears both stage valids.
// A stalled output holds its word; the lane stage keeps filling, and the
// input stalls only when both stages hold words that cannot move.
// ----------------------------------------------------------------------------
module masked_multidim_index_stepper (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_valid,
    output logic                                 o_stall,
    input  wire logic [1:0]                      i_func,
    input  wire logic                            i_flag_sel,
    input  wire logic [mmis_pkg::DIGIT_BITS-1:0] i_coord_zero,
    input  wire logic [mmis_pkg::DIGIT_BITS-1:0] i_coord_one,
    input  wire logic [mmis_pkg::DIGIT_BITS-1:0] i_coord_two,
    input  wire logic [mmis_pkg::DIGIT_BITS-1:0] i_coord_three,
    input  wire logic [mmis_pkg::DIGIT_BITS-1:0] i_other_zero,
    input  wire logic [mmis_pkg::DIGIT_BITS-1:0] i_other_one,
    input  wire logic [mmis_pkg::DIGIT_BITS-1:0] i_other_two,
    input  wire logic [mmis_pkg::DIGIT_BITS-1:0] i_other_three,
    output logic                                 o_valid,
    input  wire logic                            i_stall,
    output logic [mmis_pkg::DIGIT_BITS-1:0]      o_new_zero,
    output logic [mmis_pkg::DIGIT_BITS-1:0]      o_new_one,
    output logic [mmis_pkg::DIGIT_BITS-1:0]      o_new_two,
    output logic [mmis_pkg::DIGIT_BITS-1:0]      o_new_three,
    output logic                                 o_step_error,
    output logic                                 o_in_range,
    output logic                                 o_at_last,
    output logic                                 o_masked_equal,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [mmis_pkg::ADDR_BITS-1:0]  paddr,
    input  wire logic [mmis_pkg::DATA_BITS-1:0]  pwdata,
    output logic [mmis_pkg::DATA_BITS-1:0]       prdata,
    output logic                                 pready
);

    // Configuration registers.
    logic [mmis_pkg::DIMS_BITS-1:0] r_dims;
    logic [mmis_pkg::MASK_BITS-1:0] r_closed;
    mmis_pkg::t_extent              r_extent [mmis_pkg::LANES];

    mmis_pkg::t_reg_idx             reg_idx;
    logic                           cfg_write;
    logic [mmis_pkg::DIMS_BITS-1:0] n_used;

    // Pipeline.
    mmis_pkg::t_digit                           coord [mmis_pkg::LANES];
    mmis_pkg::t_digit                           other [mmis_pkg::LANES];
    mmis_pkg::t_lane_info [mmis_pkg::LANES-1:0] lane_info;
    mmis_pkg::t_lane_info [mmis_pkg::LANES-1:0] r_s1_lanes;
    mmis_pkg::t_func                            r_s1_func;
    logic                                       r_s1_valid;
    mmis_pkg::t_result                          merge_result;
    mmis_pkg::t_result                          r_out;
    logic                                       r_out_valid;
    logic                                       out_ready;
    logic                                       s1_ready;

    assign pready    = 1'b1;
    assign reg_idx   = mmis_pkg::t_reg_idx'(paddr[4:2]);
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dims   <= mmis_pkg::DIMS_BITS'(1);
            r_closed <= '0;
            for (int i = 0; i < mmis_pkg::LANES; i++) begin
                r_extent[i] <= mmis_pkg::EXT_BITS'(1);
            end
        end else if (cfg_write) begin
            unique case (reg_idx)
                mmis_pkg::REG_DIMS:   r_dims      <= pwdata[mmis_pkg::DIMS_BITS-1:0];
                mmis_pkg::REG_CLOSED: r_closed    <= pwdata[mmis_pkg::MASK_BITS-1:0];
                mmis_pkg::REG_EXT0:   r_extent[0] <= pwdata[mmis_pkg::EXT_BITS-1:0];
                mmis_pkg::REG_EXT1:   r_extent[1] <= pwdata[mmis_pkg::EXT_BITS-1:0];
                mmis_pkg::REG_EXT2:   r_extent[2] <= pwdata[mmis_pkg::EXT_BITS-1:0];
                mmis_pkg::REG_EXT3:   r_extent[3] <= pwdata[mmis_pkg::EXT_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            mmis_pkg::REG_DIMS:   prdata = mmis_pkg::DATA_BITS'(r_dims);
            mmis_pkg::REG_CLOSED: prdata = mmis_pkg::DATA_BITS'(r_closed);
            mmis_pkg::REG_EXT0:   prdata = mmis_pkg::DATA_BITS'(r_extent[0]);
            mmis_pkg::REG_EXT1:   prdata = mmis_pkg::DATA_BITS'(r_extent[1]);
            mmis_pkg::REG_EXT2:   prdata = mmis_pkg::DATA_BITS'(r_extent[2]);
            mmis_pkg::REG_EXT3:   prdata = mmis_pkg::DATA_BITS'(r_extent[3]);
            default:              prdata = '0;
        endcase
    end

    assign n_used = mmis_pkg::used_dims(r_dims);

    assign coord[0] = i_coord_zero;
    assign coord[1] = i_coord_one;
    assign coord[2] = i_coord_two;
    assign coord[3] = i_coord_three;
    assign other[0] = i_other_zero;
    assign other[1] = i_other_one;
    assign other[2] = i_other_two;
    assign other[3] = i_other_three;

    for (genvar g = 0; g < mmis_pkg::LANES; g++) begin : g_lane
        mmis_lane u_lane (
            .i_used     (32'(g) < 32'(n_used)),
            .i_closed   (r_closed[g]),
            .i_flag_sel (i_flag_sel),
            .i_coord    (coord[g]),
            .i_other    (other[g]),
            .i_extent   (r_extent[g]),
            .o_info     (lane_info[g])
        );
    end

    mmis_merge u_merge (
        .i_func   (r_s1_func),
        .i_lanes  (r_s1_lanes),
        .o_result (merge_result)
    );

    assign out_ready = !r_out_valid || !i_stall;
    assign s1_ready  = !r_s1_valid || out_ready;
    assign o_stall   = !s1_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s1_ready) begin
                r_s1_valid <= i_valid;
            end
            if (out_ready) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_ready && i_valid) begin
            r_s1_lanes <= lane_info;
            r_s1_func  <= mmis_pkg::t_func'(i_func);
        end
        if (out_ready && r_s1_valid) begin
            r_out <= merge_result;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_new_zero     = r_out.digits[0];
    assign o_new_one      = r_out.digits[1];
    assign o_new_two      = r_out.digits[2];
    assign o_new_three    = r_out.digits[3];
    assign o_step_error   = r_out.step_error;
    assign o_in_range     = r_out.in_range;
    assign o_at_last      = r_out.at_last;
    assign o_masked_equal = r_out.masked_equal;

    // Zeroing and query words never report a step error.
    a_no_err_on_query: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && ((r_s1_func == mmis_pkg::FUNC_ZERO) || (r_s1_func == mmis_pkg::FUNC_QUERY))
        |-> !merge_result.step_error)
        else $error("step error raised on a zeroing or query word");

    // An accepted word always lands in the lane stage.
    a_accept_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> r_s1_valid)
        else $error("accepted word lost before the lane stage");

    // A lane-stage word that may advance shows up at the output.
    a_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && out_ready |=> o_valid)
        else $error("lane-stage word did not reach the output");

    // With both stages full and the output blocked, the input must stall.
    a_full_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && o_valid && i_stall |-> o_stall)
        else $error("input not stalled while the pipeline is full");

endmodule
`default_nettype wire

/* test/tb_masked_multidim_index_stepper.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_masked_multidim_index_stepper
// Self-checking bench for the masked mixed-radix index stepper. Words are fed
// through the valid/stall input channel with random gaps, results are taken
// with random output stalls, and every result is compared field by field
// against a local model of the stepper. Register settings are changed over
// APB between phases while the block is idle, including the out-of-range
// dimension counts and extents.
// ----------------------------------------------------------------------------
module tb_masked_multidim_index_stepper;

    import mmis_pkg::*;

    localparam int IDLE_PCT       = 36;
    localparam int STUCK_LIMIT    = 2000;
    localparam int RANDOM_PHASES  = 8;
    localparam int WORDS_PER_PASS = 150;
    localparam int REG_SPARE_LO   = 6;
    localparam int REG_SPARE_HI   = 7;

    typedef struct packed {
        t_func              func;
        logic               sel;
        t_digit [LANES-1:0] coord;
        t_digit [LANES-1:0] other;
    } index_word_t;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_valid = 1'b0;
    logic                  o_stall;
    logic [1:0]            i_func = '0;
    logic                  i_flag_sel = 1'b0;
    t_digit                i_coord_zero = '0;
    t_digit                i_coord_one = '0;
    t_digit                i_coord_two = '0;
    t_digit                i_coord_three = '0;
    t_digit                i_other_zero = '0;
    t_digit                i_other_one = '0;
    t_digit                i_other_two = '0;
    t_digit                i_other_three = '0;
    logic                  o_valid;
    logic                  i_stall = 1'b0;
    t_digit                o_new_zero;
    t_digit                o_new_one;
    t_digit                o_new_two;
    t_digit                o_new_three;
    logic                  o_step_error;
    logic                  o_in_range;
    logic                  o_at_last;
    logic                  o_masked_equal;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [ADDR_BITS-1:0]  paddr = '0;
    logic [DATA_BITS-1:0]  pwdata = '0;
    logic [DATA_BITS-1:0]  prdata;
    logic                  pready;

    masked_multidim_index_stepper DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_func         (i_func),
        .i_flag_sel     (i_flag_sel),
        .i_coord_zero   (i_coord_zero),
        .i_coord_one    (i_coord_one),
        .i_coord_two    (i_coord_two),
        .i_coord_three  (i_coord_three),
        .i_other_zero   (i_other_zero),
        .i_other_one    (i_other_one),
        .i_other_two    (i_other_two),
        .i_other_three  (i_other_three),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_new_zero     (o_new_zero),
        .o_new_one      (o_new_one),
        .o_new_two      (o_new_two),
        .o_new_three    (o_new_three),
        .o_step_error   (o_step_error),
        .o_in_range     (o_in_range),
        .o_at_last      (o_at_last),
        .o_masked_equal (o_masked_equal),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    // Shadow copy of the register file.
    logic [DIMS_BITS-1:0] cfg_dims = DIMS_BITS'(1);
    logic [MASK_BITS-1:0] cfg_closed = '0;
    t_extent              cfg_ext [LANES] = '{default: EXT_BITS'(1)};

    index_word_t          pending_words[$];
    t_result              predicted_results[$];
    index_word_t          cur_word;
    t_result              want;
    t_digit [LANES-1:0]   cursor;
    logic                 walk_sel = 1'b0;
    logic                 quiet = 1'b0;
    int                   n_queued = 0;
    int                   n_accepted = 0;
    int                   n_checked = 0;
    int                   n_step_err = 0;
    int                   n_settings = 0;
    int                   failures = 0;
    int                   stuck = 0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Effective size of a dimension: zero acts as one, anything beyond the
    // digit range saturates.
    function automatic int unsigned span_of(input int d);
        int unsigned e;
        e = cfg_ext[d];
        if (e == 0) e = 1;
        if (e > (1 << DIGIT_BITS)) e = 1 << DIGIT_BITS;
        return e;
    endfunction

    function automatic t_result step_index(input index_word_t w);
        t_result     r;
        int unsigned dig [LANES];
        int unsigned e;
        logic [LANES-1:0] hit;
        int          n;
        int          k;
        logic        done;
        logic        bad;
        logic        ok_range;
        logic        last;
        logic        same;
        n = int'(cfg_dims);
        if (n == 0) n = 1;
        if (n > MAX_DIMS) n = MAX_DIMS;
        if (n > LANES) n = LANES;
        ok_range = 1'b1;
        last = 1'b1;
        same = 1'b1;
        for (k = 0; k < LANES; k++) begin
            dig[k] = w.coord[k];
            hit[k] = (k < n) && (cfg_closed[k] == w.sel);
        end
        for (k = 0; k < n; k++) begin
            e = span_of(k);
            if (dig[k] >= e) ok_range = 1'b0;
            if (hit[k]) begin
                if (dig[k] != e - 1) last = 1'b0;
                if (w.coord[k] != w.other[k]) same = 1'b0;
            end
        end
        done = 1'b0;
        bad = 1'b0;
        if (w.func == FUNC_INC || w.func == FUNC_DEC) begin
            // Fastest matching digit first; a carry or borrow moves on to the
            // next slower matching digit.
            for (k = n - 1; k >= 0 && !done && !bad; k--) begin
                if (hit[k]) begin
                    e = span_of(k);
                    if (w.func == FUNC_INC) begin
                        if (dig[k] < e - 1) begin
                            dig[k]++;
                            done = 1'b1;
                        end else if (dig[k] == e - 1) begin
                            dig[k] = 0;
                        end else begin
                            bad = 1'b1;
                        end
                    end else begin
                        if (dig[k] == 0) begin
                            dig[k] = e - 1;
                        end else if (dig[k] < e) begin
                            dig[k]--;
                            done = 1'b1;
                        end else begin
                            bad = 1'b1;
                        end
                    end
                end
            end
            if (!done) bad = 1'b1;
        end else if (w.func == FUNC_ZERO) begin
            for (k = 0; k < n; k++) begin
                if (hit[k]) dig[k] = 0;
            end
        end
        for (k = 0; k < LANES; k++) begin
            r.digits[k] = t_digit'(dig[k]);
        end
        r.step_error = bad;
        r.in_range = ok_range;
        r.at_last = last;
        r.masked_equal = same;
        return r;
    endfunction

    task automatic reg_write(input int unsigned idx, input logic [DATA_BITS-1:0] value);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= ADDR_BITS'(idx * 4);
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_DIMS:   cfg_dims = value[DIMS_BITS-1:0];
            REG_CLOSED: cfg_closed = value[MASK_BITS-1:0];
            REG_EXT0:   cfg_ext[0] = value[EXT_BITS-1:0];
            REG_EXT1:   cfg_ext[1] = value[EXT_BITS-1:0];
            REG_EXT2:   cfg_ext[2] = value[EXT_BITS-1:0];
            REG_EXT3:   cfg_ext[3] = value[EXT_BITS-1:0];
            default: ;
        endcase
    endtask

    task automatic program_regs(input logic [DATA_BITS-1:0] dims, mask,
                                input logic [DATA_BITS-1:0] e0, e1, e2, e3);
        reg_write(REG_DIMS, dims);
        reg_write(REG_CLOSED, mask);
        reg_write(REG_EXT0, e0);
        reg_write(REG_EXT1, e1);
        reg_write(REG_EXT2, e2);
        reg_write(REG_EXT3, e3);
        n_settings++;
    endtask

    // Wait until every queued word has come back and been checked.
    task automatic settle();
        wait (n_checked == n_queued);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic queue_word(input t_func f, input logic s,
                              input t_digit c0, c1, c2, c3,
                              input t_digit x0, x1, x2, x3);
        index_word_t w;
        w.func = f;
        w.sel = s;
        w.coord = {c3, c2, c1, c0};
        w.other = {x3, x2, x1, x0};
        pending_words.push_back(w);
        n_queued++;
    endtask

    function automatic t_digit pick_digit(input int d);
        int unsigned e;
        int unsigned r;
        e = span_of(d);
        r = $urandom_range(99);
        if (r < 50) return t_digit'($urandom_range(e - 1));
        if (r < 75) return t_digit'(e - 1);
        if (r < 85) return '0;
        return t_digit'($urandom_range(65535));
    endfunction

    function automatic logic [DATA_BITS-1:0] pick_extent();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 55) return $urandom_range(6, 1);
        if (r < 65) return 65536;
        if (r < 72) return 0;
        if (r < 78) return $urandom_range(131071, 65537);
        if (r < 88) return 1;
        return $urandom_range(65536, 1);
    endfunction

    // Most words continue a walk through the index space from the previous
    // predicted result; the rest start from a fresh random tuple.
    task automatic queue_random_word();
        index_word_t w;
        t_result     nxt;
        int unsigned r;
        int          d;
        r = $urandom_range(99);
        for (d = 0; d < LANES; d++) begin
            w.coord[d] = (r < 70) ? cursor[d] : pick_digit(d);
        end
        r = $urandom_range(99);
        if (r < 40) w.func = FUNC_INC;
        else if (r < 80) w.func = FUNC_DEC;
        else if (r < 90) w.func = FUNC_ZERO;
        else w.func = FUNC_QUERY;
        if ($urandom_range(9) == 0) walk_sel = ~walk_sel;
        w.sel = walk_sel;
        for (d = 0; d < LANES; d++) begin
            r = $urandom_range(99);
            if (r < 60) w.other[d] = w.coord[d];
            else if (r < 80) w.other[d] = w.coord[d] ^ t_digit'(1 << $urandom_range(15));
            else w.other[d] = t_digit'($urandom_range(65535));
        end
        nxt = step_index(w);
        cursor = nxt.digits;
        pending_words.push_back(w);
        n_queued++;
    endtask

    task automatic check_field(input string name, input int unsigned exp_v,
                               input int unsigned got_v);
        if (exp_v != got_v) begin
            $error("%s mismatch: expected %0d, got %0d", name, exp_v, got_v);
            failures++;
        end
    endtask

    // Input side: a word is held until it is taken.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                want = step_index(cur_word);
                predicted_results.push_back(want);
                if (want.step_error) n_step_err++;
                n_accepted++;
            end
            if (!i_valid || !o_stall) begin
                if (pending_words.size() > 0 && (quiet || $urandom_range(99) >= IDLE_PCT)) begin
                    cur_word = pending_words.pop_front();
                    i_valid <= 1'b1;
                    i_func <= cur_word.func;
                    i_flag_sel <= cur_word.sel;
                    i_coord_zero <= cur_word.coord[0];
                    i_coord_one <= cur_word.coord[1];
                    i_coord_two <= cur_word.coord[2];
                    i_coord_three <= cur_word.coord[3];
                    i_other_zero <= cur_word.other[0];
                    i_other_one <= cur_word.other[1];
                    i_other_two <= cur_word.other[2];
                    i_other_three <= cur_word.other[3];
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Output side: random back-pressure and result checking.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                if (predicted_results.size() == 0) begin
                    $error("result word with no pending prediction");
                    failures++;
                end else begin
                    t_result exp_r;
                    exp_r = predicted_results.pop_front();
                    check_field("new_zero", exp_r.digits[0], o_new_zero);
                    check_field("new_one", exp_r.digits[1], o_new_one);
                    check_field("new_two", exp_r.digits[2], o_new_two);
                    check_field("new_three", exp_r.digits[3], o_new_three);
                    check_field("step_error", exp_r.step_error, o_step_error);
                    check_field("in_range", exp_r.in_range, o_in_range);
                    check_field("at_last", exp_r.at_last, o_at_last);
                    check_field("masked_equal", exp_r.masked_equal, o_masked_equal);
                    n_checked++;
                end
            end
            i_stall <= !quiet && ($urandom_range(99) < IDLE_PCT);
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || psel ||
            (pending_words.size() == 0 && n_checked == n_queued)) begin
            stuck <= 0;
        end else begin
            stuck <= stuck + 1;
        end
    end

    initial begin
        wait (stuck >= STUCK_LIMIT);
        $error("no handshake for %0d cycles with words outstanding", STUCK_LIMIT);
        $display("Regression FAIL");
        $finish;
    end

    initial begin
        int ph;
        int j;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Register values straight out of reset: one open dimension of size one.
        queue_word(FUNC_INC, 1'b0, 16'd0, 16'hFFFF, 16'h1234, 16'hFFFF,
                   16'd0, 16'd0, 16'd0, 16'd0);
        queue_word(FUNC_QUERY, 1'b1, 16'd0, 16'd0, 16'd0, 16'd0,
                   16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        settle();

        // Three dimensions, dimension one closed, dimension three unused.
        program_regs(3, 4'b1010, 3, 5, 65536, 0);
        queue_word(FUNC_INC, 1'b0, 16'd2, 16'd4, 16'hFFFF, 16'hFFFF,
                   16'd2, 16'd4, 16'hFFFF, 16'hFFFF);
        queue_word(FUNC_DEC, 1'b0, 16'd0, 16'd0, 16'd0, 16'd0,
                   16'd0, 16'd0, 16'd0, 16'd0);
        queue_word(FUNC_INC, 1'b0, 16'd1, 16'd3, 16'd100, 16'd0,
                   16'd1, 16'd0, 16'd100, 16'd0);
        queue_word(FUNC_DEC, 1'b0, 16'd1, 16'd0, 16'd0, 16'd0,
                   16'd1, 16'd0, 16'd1, 16'd0);
        queue_word(FUNC_INC, 1'b0, 16'd7, 16'd0, 16'hFFFF, 16'd0,
                   16'd7, 16'd0, 16'hFFFF, 16'd0);
        queue_word(FUNC_DEC, 1'b0, 16'd9, 16'd0, 16'd5, 16'd0,
                   16'd9, 16'd0, 16'd5, 16'd0);
        queue_word(FUNC_INC, 1'b1, 16'd0, 16'd4, 16'd0, 16'd0,
                   16'd0, 16'd4, 16'd0, 16'd0);
        queue_word(FUNC_INC, 1'b1, 16'd0, 16'd2, 16'd0, 16'd0,
                   16'd0, 16'd2, 16'd0, 16'd0);
        queue_word(FUNC_DEC, 1'b1, 16'd0, 16'd6, 16'd0, 16'd0,
                   16'd0, 16'd6, 16'd0, 16'd0);
        queue_word(FUNC_ZERO, 1'b0, 16'd2, 16'd4, 16'hFFFF, 16'hABCD,
                   16'd0, 16'd0, 16'd0, 16'd0);
        queue_word(FUNC_ZERO, 1'b1, 16'd2, 16'd4, 16'hFFFF, 16'hFFFF,
                   16'd2, 16'd4, 16'hFFFF, 16'hFFFF);
        queue_word(FUNC_QUERY, 1'b0, 16'd2, 16'd1, 16'hFFFF, 16'd0,
                   16'd2, 16'd0, 16'hFFFF, 16'hFFFF);
        queue_word(FUNC_QUERY, 1'b1, 16'd0, 16'd0, 16'd0, 16'd0,
                   16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        settle();

        // Dimension count of zero acts as one; every dimension closed, so
        // the open class has nothing to step.
        program_regs(0, 4'hF, 0, 131071, 131071, 131071);
        queue_word(FUNC_INC, 1'b0, 16'd0, 16'd0, 16'd0, 16'd0,
                   16'd1, 16'd1, 16'd1, 16'd1);
        queue_word(FUNC_DEC, 1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                   16'd0, 16'd0, 16'd0, 16'd0);
        queue_word(FUNC_INC, 1'b1, 16'd0, 16'd0, 16'd0, 16'd0,
                   16'd0, 16'd0, 16'd0, 16'd0);
        queue_word(FUNC_DEC, 1'b1, 16'hFFFF, 16'd0, 16'd0, 16'd0,
                   16'hFFFF, 16'd0, 16'd0, 16'd0);
        queue_word(FUNC_ZERO, 1'b1, 16'd5, 16'd5, 16'd5, 16'd5,
                   16'd5, 16'd5, 16'd5, 16'd5);
        settle();

        // Count above the lane limit and saturating extents; the spare
        // register slots must have no effect.
        program_regs(7, 4'h0, 131071, 131071, 131071, 131071);
        reg_write(REG_SPARE_LO, 32'hFFFF_FFFF);
        reg_write(REG_SPARE_HI, 32'h0000_0001);
        queue_word(FUNC_INC, 1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                   16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        queue_word(FUNC_DEC, 1'b0, 16'd0, 16'd0, 16'd0, 16'd0,
                   16'd0, 16'd0, 16'd0, 16'd0);
        queue_word(FUNC_INC, 1'b1, 16'd1, 16'd2, 16'd3, 16'd4,
                   16'd1, 16'd2, 16'd3, 16'd4);
        queue_word(FUNC_QUERY, 1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                   16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        queue_word(FUNC_DEC, 1'b0, 16'd0, 16'd0, 16'd0, 16'd1,
                   16'd0, 16'd0, 16'd0, 16'd0);
        settle();

        for (ph = 0; ph < RANDOM_PHASES; ph++) begin
            case (ph)
                0: program_regs(4, 4'b0101, 65536, 65536, 65536, 65536);
                1: program_regs(4, 4'b0000, 2, 2, 2, 2);
                default: program_regs(($urandom_range(9) < 8) ? $urandom_range(4, 1)
                                                                : $urandom_range(7),
                                      $urandom_range(15), pick_extent(), pick_extent(),
                                      pick_extent(), pick_extent());
            endcase
            // One pass runs with no gaps and no back-pressure at all.
            quiet = (ph == 2);
            for (j = 0; j < LANES; j++) begin
                cursor[j] = pick_digit(j);
            end
            for (j = 0; j < WORDS_PER_PASS; j++) begin
                queue_random_word();
            end
            settle();
        end
        quiet = 1'b0;

        wait (n_checked == n_queued);
        repeat (10) @(posedge i_clk);
        $display("Stepped %0d words across %0d register settings, %0d of them flagged",
                 n_accepted, n_settings, n_step_err);
        $display("as step errors; all four operations and both dimension classes exercised.");
        if (failures == 0 && predicted_results.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
